/* rtl/adf_pkg.sv */
// ----------------------------------------------------------------------------
// Advertising data name filter package
// Shared types, sizes and codes for the advertising data name filter.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int MAX_AD_LEN_DEFAULT = 31;
  localparam int MAX_NAME_LEN       = 29;
  localparam int NAME_BYTES         = 29;
  localparam int NAME_IDX_W         = $clog2(NAME_BYTES);
  localparam int BYTE_W             = 8;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 64;
  localparam int NAME_LEN_W         = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_B = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_C = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_D = 3'd4;

  localparam logic [BYTE_W-1:0] AD_TYPE_SHORT_NAME    = 8'h08;
  localparam logic [BYTE_W-1:0] AD_TYPE_COMPLETE_NAME = 8'h09;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_MATCH = 2'd1,
    VERDICT_BAD   = 2'd2
  } verdict_t;

endpackage

/* rtl/adv_data_name_filter_core.sv */
// ----------------------------------------------------------------------------
// Advertising data name filter core
// Walks the length-type-value elements of one advertising payload and gives
// one verdict per payload: no match, local name matched, or malformed.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake              Content
//  s_axis     in   tvalid/tready          tdata[7:0] payload_byte, tlast final_byte
//  m_axis     out  tvalid/tready          tdata[1:0] verdict
//  cfg        in   cfg_write              cfg_index, cfg_data (target name)
//
// Items are handled as they are accepted, and a new item is taken each cycle
// while the verdict register is empty or being drained. A verdict is
// registered at the edge that accepts the final item of a payload and is
// offered in the next cycle. The input stalls only while a verdict waits and
// the output is stalled. Reset clears the parse state and the target name
// registers.
// ----------------------------------------------------------------------------
module adv_data_name_filter_core #(
  parameter int MAX_AD_LEN = adf_pkg::MAX_AD_LEN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] payload_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [1:0] verdict
  input  logic                            cfg_write,
  input  logic [adf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [adf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adf_pkg::*;

  localparam int SEEN_W = $clog2(MAX_AD_LEN + 2);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_VALUE
  } phase_t;

  logic [NAME_LEN_W-1:0]           target_len;
  logic [NAME_BYTES-1:0][BYTE_W-1:0] target_name;

  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   element_left, element_left_next;
  logic                name_element, name_element_next;
  logic                name_equal, name_equal_next;
  logic [BYTE_W-1:0]   name_index, name_index_next;
  logic [BYTE_W-1:0]   value_length, value_length_next;
  verdict_t            decided, decided_next;
  logic [SEEN_W-1:0]   bytes_seen, bytes_seen_next;

  logic              accept;
  logic [BYTE_W-1:0] b;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign b             = s_axis_tdata;

  always_comb begin
    logic close_now;
    close_now         = 1'b0;
    phase_next        = phase;
    element_left_next = element_left;
    name_element_next = name_element;
    name_equal_next   = name_equal;
    name_index_next   = name_index;
    value_length_next = value_length;
    decided_next      = decided;
    bytes_seen_next   = bytes_seen;

    if (bytes_seen <= SEEN_W'(MAX_AD_LEN)) begin
      bytes_seen_next = bytes_seen + 1'b1;
    end

    if (decided == VERDICT_NONE) begin
      unique case (phase)
        PH_LEN: begin
          if (b == '0) begin
            decided_next = VERDICT_BAD;
          end else begin
            value_length_next = b - 1'b1;
            element_left_next = b - 1'b1;
            phase_next        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          name_element_next = (b == AD_TYPE_SHORT_NAME) || (b == AD_TYPE_COMPLETE_NAME);
          name_equal_next   = name_element_next &&
                              (target_len <= NAME_LEN_W'(MAX_NAME_LEN)) &&
                              (value_length == {{(BYTE_W-NAME_LEN_W){1'b0}}, target_len});
          name_index_next   = '0;
          if (element_left == '0) begin
            close_now = 1'b1;
          end else begin
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (name_element) begin
            if ((name_index >= BYTE_W'(MAX_NAME_LEN)) ||
                (name_index >= {{(BYTE_W-NAME_LEN_W){1'b0}}, target_len}) ||
                (target_name[name_index[NAME_IDX_W-1:0]] != b)) begin
              name_equal_next = 1'b0;
            end
            if (name_index != '1) begin
              name_index_next = name_index + 1'b1;
            end
          end
          if (element_left != '0) begin
            element_left_next = element_left - 1'b1;
          end
          if (element_left_next == '0) begin
            close_now = 1'b1;
          end
        end
        default: begin
          phase_next = PH_LEN;
        end
      endcase

      if (close_now) begin
        if (name_element_next && name_equal_next && (name_index_next == value_length_next)) begin
          decided_next = VERDICT_MATCH;
        end
        phase_next        = PH_LEN;
        name_element_next = 1'b0;
        name_equal_next   = 1'b0;
        name_index_next   = '0;
      end

      if (s_axis_tlast && (decided_next == VERDICT_NONE) && (phase_next != PH_LEN)) begin
        decided_next = VERDICT_BAD;
      end
    end

    if (bytes_seen_next > SEEN_W'(MAX_AD_LEN)) begin
      decided_next = VERDICT_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_len    <= '0;
      target_name   <= '0;
      phase         <= PH_LEN;
      element_left  <= '0;
      name_element  <= 1'b0;
      name_equal    <= 1'b0;
      name_index    <= '0;
      value_length  <= '0;
      decided       <= VERDICT_NONE;
      bytes_seen    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NAME_LENGTH:  target_len         <= cfg_data[NAME_LEN_W-1:0];
          REG_NAME_BYTES_A: target_name[7:0]   <= cfg_data;
          REG_NAME_BYTES_B: target_name[15:8]  <= cfg_data;
          REG_NAME_BYTES_C: target_name[23:16] <= cfg_data;
          REG_NAME_BYTES_D: target_name[28:24] <= cfg_data[39:0];
          default: begin
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && !(accept && s_axis_tlast)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (accept) begin
        if (s_axis_tlast) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {6'b0, decided_next};
          phase         <= PH_LEN;
          element_left  <= '0;
          name_element  <= 1'b0;
          name_equal    <= 1'b0;
          name_index    <= '0;
          value_length  <= '0;
          decided       <= VERDICT_NONE;
          bytes_seen    <= '0;
        end else begin
          phase         <= phase_next;
          element_left  <= element_left_next;
          name_element  <= name_element_next;
          name_equal    <= name_equal_next;
          name_index    <= name_index_next;
          value_length  <= value_length_next;
          decided       <= decided_next;
          bytes_seen    <= bytes_seen_next;
        end
      end
    end
  end

  a_final_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> m_axis_tvalid)
    else $error("final item did not produce a verdict");

  a_final_clears_packet: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=>
      (phase == PH_LEN) && (decided == VERDICT_NONE) && (bytes_seen == '0))
    else $error("packet state not cleared after final item");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:2] == '0))
    else $error("invalid verdict code");

  a_name_only_in_value: assert property (@(posedge clk) disable iff (rst)
    name_element |-> (phase == PH_VALUE))
    else $error("name element flag outside a value");

endmodule
